// ===== sv/rcsa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcsa_pkg
// Shared types and codes of the reference-counted slot allocator.
// ----------------------------------------------------------------------------
package rcsa_pkg;

	// Command codes; codes 5 to 7 are undefined and rejected.
	typedef enum logic [2:0] {
		CMD_ALLOC = 3'd0,
		CMD_INC   = 3'd1,
		CMD_DEC   = 3'd2,
		CMD_FIND  = 3'd3,
		CMD_CHECK = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_NONE  = 2'd1,
		ST_RANGE = 2'd2,
		ST_FREE  = 2'd3
	} status_t;

	// Sequencer states, one-hot.
	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EVAL = 2'b10
	} state_t;

	localparam int SLOT_ID_W = 8;
	localparam int COUNT_OUT_W = 16;

endpackage

// ===== sv/refcounted_slot_allocator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refcounted_slot_allocator_core
// Free-list slot allocator with saturating per-slot reference counts.
// ----------------------------------------------------------------------------
// A word accepted in S_IDLE is latched and moves the sequencer to S_EVAL; done
//   is registered from S_EVAL and busy drops with it, so one word at a time.
// Find walks one slot per cycle through the slot RAM read port, bounded by the
//   high-water mark of allocated slots.
// Reset: free list, counts and flags go back to a pool with every slot free at
//   once; slots never handed out are recognized by the high-water mark, so no
//   clearing pass.
// The receiver cannot stall: done is high for exactly one cycle per word.
// ----------------------------------------------------------------------------
module refcounted_slot_allocator_core #(
	parameter int SLOTS       = 256,
	parameter int COUNT_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [2:0]                          command,
	input  logic [rcsa_pkg::SLOT_ID_W-1:0]      slot_id,
	output logic                                done,
	output logic [rcsa_pkg::SLOT_ID_W-1:0]      result_slot,
	output logic [1:0]                          status,
	output logic [rcsa_pkg::COUNT_OUT_W-1:0]    ref_count_out,
	output logic                                slot_freed
);

	// Slot index width, and width of head / high-water values that can hold SLOTS.
	localparam int AW = $clog2(SLOTS);
	localparam int HW = $clog2(SLOTS + 1);
	localparam int CW = COUNT_WIDTH;
	localparam int IDW = rcsa_pkg::SLOT_ID_W;
	localparam int OCW = rcsa_pkg::COUNT_OUT_W;

	// ------------------------------------------------------------------------
	// Control state
	// ------------------------------------------------------------------------
	rcsa_pkg::state_t state_q, state_d;
	logic [HW-1:0]    head_q, head_d;    // free-list head, SLOTS = empty
	logic [HW-1:0]    fresh_q, fresh_d;  // slots >= fresh_q were never handed out
	logic             done_q;

	// Latched command word
	logic [2:0]       cmd_q;
	logic [IDW-1:0]   id_q;
	logic [AW-1:0]    idx_q, idx_d;      // slot address; also the find cursor
	logic             oor_q;             // slot_id beyond the pool

	// Result registers
	logic [IDW-1:0]   res_slot_q, res_slot_d;
	logic [1:0]       res_status_q, res_status_d;
	logic [OCW-1:0]   res_count_q, res_count_d;
	logic             res_freed_q, res_freed_d;
	logic             finish;

	logic accept;
	assign accept = start && (state_q == rcsa_pkg::S_IDLE);

	// ------------------------------------------------------------------------
	// Memories: link RAM holds next pointers of pushed slots; slot RAM holds
	// {allocated flag, count}. Both are written only once a slot is in use.
	// ------------------------------------------------------------------------
	logic             link_we;
	logic [AW-1:0]    link_waddr, link_raddr;
	logic [HW-1:0]    link_wdata, link_rdata;

	logic             slot_we;
	logic [AW-1:0]    slot_waddr, slot_raddr;
	logic [CW:0]      slot_wdata, slot_rdata;

	rcsa_ram #(.WIDTH(HW), .DEPTH(SLOTS)) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.raddr (link_raddr),
		.rdata (link_rdata)
	);

	rcsa_ram #(.WIDTH(CW + 1), .DEPTH(SLOTS)) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (slot_wdata),
		.raddr (slot_raddr),
		.rdata (slot_rdata)
	);

	// Read data decode; entries at or above the high-water mark read as free, zero.
	logic          rd_flag;
	logic [CW-1:0] rd_cnt;
	logic          cur_seen;
	logic          cur_live;
	logic [HW-1:0] idx_ext;
	logic [HW-1:0] idx_nxt;
	logic          head_empty;
	logic          head_fresh;
	logic [CW-1:0] cnt_inc, cnt_dec;

	assign rd_flag    = slot_rdata[CW];
	assign rd_cnt     = slot_rdata[CW-1:0];
	assign idx_ext    = HW'(idx_q);
	assign idx_nxt    = idx_ext + HW'(1);
	assign cur_seen   = idx_ext < fresh_q;
	assign cur_live   = cur_seen && rd_flag;
	assign head_empty = head_q == HW'(SLOTS);
	assign head_fresh = head_q == fresh_q;
	assign cnt_inc    = (rd_cnt == {CW{1'b1}}) ? rd_cnt : rd_cnt + CW'(1);
	assign cnt_dec    = (rd_cnt == '0) ? rd_cnt : rd_cnt - CW'(1);

	// Link RAM is only read for allocate, at the head.
	assign link_raddr = head_q[AW-1:0];

	// ------------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------------
	always_comb begin
		state_d      = state_q;
		head_d       = head_q;
		fresh_d      = fresh_q;
		idx_d        = idx_q;
		finish       = 1'b0;
		res_slot_d   = id_q;
		res_status_d = rcsa_pkg::ST_OK;
		res_count_d  = '0;
		res_freed_d  = 1'b0;
		link_we      = 1'b0;
		link_waddr   = idx_q;
		link_wdata   = head_q;
		slot_we      = 1'b0;
		slot_waddr   = idx_q;
		slot_wdata   = '0;
		slot_raddr   = AW'(slot_id);

		unique case (state_q)
			rcsa_pkg::S_IDLE: begin
				if (start) begin
					state_d = rcsa_pkg::S_EVAL;
					idx_d   = AW'(slot_id);
				end
			end
			rcsa_pkg::S_EVAL: begin
				finish     = 1'b1;
				slot_raddr = idx_q;
				unique case (cmd_q)
					rcsa_pkg::CMD_ALLOC: begin
						res_slot_d = IDW'(head_q);
						if (head_empty) begin
							res_slot_d   = '0;
							res_status_d = rcsa_pkg::ST_NONE;
						end else begin
							slot_we    = 1'b1;
							slot_waddr = head_q[AW-1:0];
							slot_wdata = {1'b1, {CW{1'b0}}};
							if (head_fresh) begin
								head_d  = head_q + HW'(1);
								fresh_d = fresh_q + HW'(1);
							end else begin
								head_d = link_rdata;
							end
						end
					end
					rcsa_pkg::CMD_INC, rcsa_pkg::CMD_DEC: begin
						if (oor_q) begin
							res_status_d = rcsa_pkg::ST_RANGE;
						end else if (!cur_live) begin
							res_status_d = rcsa_pkg::ST_FREE;
						end else if (cmd_q == rcsa_pkg::CMD_INC) begin
							slot_we     = 1'b1;
							slot_wdata  = {1'b1, cnt_inc};
							res_count_d = OCW'(cnt_inc);
						end else if (cnt_dec == '0) begin
							// Count ran out: push the slot onto the free list.
							slot_we     = 1'b1;
							slot_wdata  = '0;
							link_we     = 1'b1;
							head_d      = idx_ext;
							res_freed_d = 1'b1;
						end else begin
							slot_we     = 1'b1;
							slot_wdata  = {1'b1, cnt_dec};
							res_count_d = OCW'(cnt_dec);
						end
					end
					rcsa_pkg::CMD_FIND: begin
						if (!oor_q && cur_seen && rd_cnt != '0) begin
							res_slot_d  = IDW'(idx_q);
							res_count_d = OCW'(rd_cnt);
						end else if (oor_q || idx_nxt >= fresh_q) begin
							res_slot_d   = '0;
							res_status_d = rcsa_pkg::ST_NONE;
						end else begin
							// Step the cursor and read the next slot.
							finish     = 1'b0;
							idx_d      = AW'(idx_nxt);
							slot_raddr = AW'(idx_nxt);
						end
					end
					rcsa_pkg::CMD_CHECK: begin
						if (oor_q) begin
							res_status_d = rcsa_pkg::ST_RANGE;
						end else if (!cur_live) begin
							res_status_d = rcsa_pkg::ST_FREE;
						end else begin
							res_count_d = OCW'(rd_cnt);
						end
					end
					default: begin
						res_status_d = rcsa_pkg::ST_RANGE;
					end
				endcase
				if (finish) begin
					state_d = rcsa_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = rcsa_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rcsa_pkg::S_IDLE;
			head_q  <= '0;
			fresh_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			fresh_q <= fresh_d;
			done_q  <= finish;
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		if (accept) begin
			cmd_q <= command;
			id_q  <= slot_id;
			oor_q <= 32'(slot_id) >= 32'(SLOTS);
		end
		if (finish) begin
			res_slot_q   <= res_slot_d;
			res_status_q <= res_status_d;
			res_count_q  <= res_count_d;
			res_freed_q  <= res_freed_d;
		end
	end

	assign busy          = state_q != rcsa_pkg::S_IDLE;
	assign done          = done_q;
	assign result_slot   = res_slot_q;
	assign status        = res_status_q;
	assign ref_count_out = res_count_q;
	assign slot_freed    = res_freed_q;

	// ------------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------------
	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= fresh_q || head_q == HW'(SLOTS))
		else $error("free-list head beyond high-water mark");

	a_fresh_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fresh_q <= HW'(SLOTS))
		else $error("high-water mark beyond pool");

	a_done_after_eval: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == rcsa_pkg::S_EVAL))
		else $error("result strobe without evaluation");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted word did not raise busy");

	a_freed_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && slot_freed) |-> (status == rcsa_pkg::ST_OK && ref_count_out == '0))
		else $error("freed slot reported with bad status or count");

endmodule

// ===== sv/rcsa_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcsa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rcsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH)-1:0]         waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic [$clog2(DEPTH)-1:0]         raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
